FILE: sv/pfat_pkg.sv
// Package: shared constants, codes and types of the paged frame allocator.
`timescale 1ns / 1ps

package pfat_pkg;

    // Sizing
    localparam int MAX_PROCESSES = 16;
    localparam int MAX_FRAMES    = 1024;

    localparam int PROC_IDX_W  = $clog2(MAX_PROCESSES);
    localparam int PROC_CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int FRAME_W     = $clog2(MAX_FRAMES);
    localparam int FRAME_CNT_W = $clog2(MAX_FRAMES + 1);

    // Field widths
    localparam int MEM_SIZE_W  = 20;
    localparam int PAGE_SIZE_W = 16;
    localparam int PSIZE_W     = 16;
    localparam int PID_W       = 8;
    localparam int LADDR_W     = 16;
    localparam int STATUS_W    = 3;
    localparam int PAGE_NUM_W  = 16;
    localparam int PAGE_OFF_W  = 16;
    localparam int PADDR_W     = 20;
    localparam int GRANT_W     = 11;
    localparam int PAGES_W     = PSIZE_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 2'd1;
    localparam logic [MEM_SIZE_W-1:0]  MEM_SIZE_RST  = 20'd1024;
    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RST = 16'd128;

    // Request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_XLATE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGES  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FAULT     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_FRAMES = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

    // Divider
    localparam int DIV_DVD_W = MEM_SIZE_W;
    localparam int DIV_DVS_W = PAGE_SIZE_W;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quot;
        logic [DIV_DVS_W-1:0] rem;
    } div_rsp_t;

    // Process table entry
    typedef struct packed {
        logic [PSIZE_W-1:0]     size;
        logic [FRAME_W-1:0]     base;
        logic [FRAME_CNT_W-1:0] pages;
    } entry_t;

    typedef struct packed {
        logic                  we;
        logic [PROC_IDX_W-1:0] addr;
        entry_t                entry;
    } tab_wr_t;

    // One result
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PAGE_NUM_W-1:0] page_number;
        logic [PAGE_OFF_W-1:0] page_offset;
        logic [FRAME_W-1:0]    frame_number;
        logic [PADDR_W-1:0]    physical_address;
        logic [GRANT_W-1:0]    pages_granted;
    } result_t;

endpackage

FILE: sv/pfat_ifs.sv
// Interfaces: request, response and configuration channels.
`timescale 1ns / 1ps

interface pfat_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [pfat_pkg::PSIZE_W-1:0]  process_size;
    logic [pfat_pkg::PID_W-1:0]    process_id;
    logic [pfat_pkg::LADDR_W-1:0]  logical_address;

    modport source (output valid, action, process_size, process_id, logical_address,
                    input ready);
    modport sink   (input valid, action, process_size, process_id, logical_address,
                    output ready);
endinterface

interface pfat_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [pfat_pkg::STATUS_W-1:0]   status;
    logic [pfat_pkg::PAGE_NUM_W-1:0] page_number;
    logic [pfat_pkg::PAGE_OFF_W-1:0] page_offset;
    logic [pfat_pkg::FRAME_W-1:0]    frame_number;
    logic [pfat_pkg::PADDR_W-1:0]    physical_address;
    logic [pfat_pkg::GRANT_W-1:0]    pages_granted;

    modport source (output valid, status, page_number, page_offset, frame_number,
                    physical_address, pages_granted, input ready);
    modport sink   (input valid, status, page_number, page_offset, frame_number,
                    physical_address, pages_granted, output ready);
endinterface

interface pfat_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pfat_pkg::CFG_IDX_W-1:0]  index;
    logic [pfat_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/pfat_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pfat_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  pfat_pkg::div_req_t div_req,
    output pfat_pkg::div_rsp_t div_rsp
);

    localparam logic [pfat_pkg::DIV_CNT_W-1:0] LAST_STEP =
        pfat_pkg::DIV_CNT_W'(pfat_pkg::DIV_DVD_W - 1);

    logic                               busy_reg;
    logic                               done_reg;
    logic [pfat_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [pfat_pkg::DIV_DVD_W-1:0]     quo_reg;
    logic [pfat_pkg::DIV_DVS_W-1:0]     rem_reg;
    logic [pfat_pkg::DIV_DVS_W-1:0]     dvs_reg;

    logic [pfat_pkg::DIV_DVS_W:0]       shifted;
    logic [pfat_pkg::DIV_DVS_W+1:0]     diff;
    logic                               fits;
    logic [pfat_pkg::DIV_DVS_W-1:0]     rem_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[pfat_pkg::DIV_DVD_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_reg};
        fits     = !diff[pfat_pkg::DIV_DVS_W+1];
        rem_next = fits ? diff[pfat_pkg::DIV_DVS_W-1:0]
                        : shifted[pfat_pkg::DIV_DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            quo_reg <= div_req.dividend;
            rem_reg <= '0;
            dvs_reg <= div_req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[pfat_pkg::DIV_DVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign div_rsp.done = done_reg;
    assign div_rsp.quot = quo_reg;
    assign div_rsp.rem  = rem_reg;

    // A new division only starts once the previous one has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !busy_reg)
        else $error("divider restarted while busy");

    // Done follows the final iteration only.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");

    // A zero divisor never reaches the divider.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> div_req.divisor != '0)
        else $error("divider started with zero divisor");

endmodule

FILE: sv/pfat_ptab.sv
// Process table: one synchronous memory, one write and one registered read port.
`timescale 1ns / 1ps

module pfat_ptab
(
    input  logic                                clk,
    input  pfat_pkg::tab_wr_t                   wr,
    input  logic                                rd_en,
    input  logic [pfat_pkg::PROC_IDX_W-1:0]     rd_addr,
    output pfat_pkg::entry_t                    rd_data
);

    pfat_pkg::entry_t mem [pfat_pkg::MAX_PROCESSES];
    pfat_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/paged_frame_alloc_translate.sv
// Top level: process page table with contiguous frame allocation and address translation.
//
//  Channel | Dir | Handshake      | Payload
//  --------+-----+----------------+-----------------------------------------------------
//  cfg     | in  | valid / ready  | index (0 memory_size, 1 page_size), data
//  req     | in  | valid / ready  | action, process_size, process_id, logical_address
//  rsp     | out | valid / ready  | status, page_number, page_offset, frame_number,
//          |     |                | physical_address, pages_granted
//
// Flow: one request at a time. A translate runs from accept to result through the
//   table read, a 20-step divide for page and offset, the page-fault check, one
//   multiply stage and the add. An allocate runs one divide for the page count; the
//   first allocate after reset or a configuration write runs a second divide, for
//   the frame total, ahead of it. Bad id and full table go straight to the result.
//   The shared divider serves all of these divides.
// Reset: control registers go to their defaults; the process table is not cleared,
//   since only entries of registered processes are ever read.
// Stalls: a finished result sits in the output register while req.ready returns
//   high, so the next request runs while the sink holds off. cfg is always ready.
`timescale 1ns / 1ps

module paged_frame_alloc_translate
(
    input  logic       clk,
    input  logic       rst_n,
    pfat_cfg_if.sink   cfg,
    pfat_req_if.sink   req,
    pfat_rsp_if.source rsp
);

    // FSM codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FRAMES = 4'd1;  // divide memory_size for frame total
    localparam logic [3:0] S_PAGES  = 4'd2;  // divide process size for page count
    localparam logic [3:0] S_ALLOC  = 4'd3;  // fit check and table write
    localparam logic [3:0] S_RDTAB  = 4'd4;  // issue table read
    localparam logic [3:0] S_CHECK  = 4'd5;  // id entry back: page/bound checks
    localparam logic [3:0] S_XDIV   = 4'd6;  // divide address for page/offset
    localparam logic [3:0] S_MUL    = 4'd7;  // frame * page size
    localparam logic [3:0] S_PHYS   = 4'd8;  // add offset
    localparam logic [3:0] S_EMIT   = 4'd9;  // hand result to output register

    logic [3:0] state_reg;

    // Configuration and cached frame total
    logic [pfat_pkg::MEM_SIZE_W-1:0]  memory_size_reg;
    logic [pfat_pkg::PAGE_SIZE_W-1:0] page_size_reg;
    logic [pfat_pkg::PAGE_SIZE_W-1:0] eff_ps;
    logic [pfat_pkg::FRAME_CNT_W-1:0] frames_reg;
    logic                             frames_ok_reg;

    // Allocation state
    logic [pfat_pkg::PROC_CNT_W-1:0]  count_reg;
    logic [pfat_pkg::FRAME_CNT_W-1:0] nff_reg;

    // Latched request
    logic [pfat_pkg::PSIZE_W-1:0]     size_reg;
    logic [pfat_pkg::PID_W-1:0]       pid_reg;
    logic [pfat_pkg::LADDR_W-1:0]     addr_reg;

    // Working registers
    logic [pfat_pkg::PAGES_W-1:0]     pages_reg;
    logic [pfat_pkg::PAGE_NUM_W-1:0]  pg_reg;
    logic [pfat_pkg::PAGE_OFF_W-1:0]  off_reg;
    logic [pfat_pkg::FRAME_W-1:0]     frame_reg;
    logic [pfat_pkg::FRAME_W+pfat_pkg::PAGE_SIZE_W-1:0] prod_reg;
    pfat_pkg::entry_t                 ent_reg;
    pfat_pkg::result_t                res_reg;

    // Output register
    pfat_pkg::result_t                out_reg;
    logic                             out_valid_reg;

    // Submodule links
    pfat_pkg::div_req_t               div_req;
    pfat_pkg::div_rsp_t               div_rsp;
    pfat_pkg::tab_wr_t                tab_wr;
    logic                             tab_rd_en;
    logic [pfat_pkg::PROC_IDX_W-1:0]  tab_rd_addr;
    pfat_pkg::entry_t                 tab_rd_data;

    // Combinational helpers
    logic                             req_fire;
    logic                             emit_go;
    logic [pfat_pkg::PAGES_W:0]       fit_sum;
    logic                             fit_ok;
    logic [pfat_pkg::PAGES_W-1:0]     pages_next;
    logic [pfat_pkg::FRAME_CNT_W-1:0] frames_next;
    pfat_pkg::result_t                res_start;

    assign eff_ps   = (page_size_reg == '0) ? pfat_pkg::PAGE_SIZE_W'(1) : page_size_reg;
    assign req_fire = req.valid && req.ready;
    assign emit_go  = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // Clamp the frame total; ceiling of size over page size.
    assign frames_next = (div_rsp.quot > pfat_pkg::DIV_DVD_W'(pfat_pkg::MAX_FRAMES))
                       ? pfat_pkg::FRAME_CNT_W'(pfat_pkg::MAX_FRAMES)
                       : pfat_pkg::FRAME_CNT_W'(div_rsp.quot);
    assign pages_next  = pfat_pkg::PAGES_W'(div_rsp.quot[pfat_pkg::PSIZE_W-1:0])
                       + pfat_pkg::PAGES_W'(div_rsp.rem != '0);
    assign fit_sum     = (pfat_pkg::PAGES_W+1)'(nff_reg) + (pfat_pkg::PAGES_W+1)'(pages_reg);
    assign fit_ok      = fit_sum <= (pfat_pkg::PAGES_W+1)'(frames_reg);

    // Starting result of a new request: the early-exit status, all else zero.
    always_comb
    begin
        res_start        = '0;
        res_start.status = (req.action == pfat_pkg::ACT_ALLOC) ? pfat_pkg::ST_FULL
                                                                : pfat_pkg::ST_BAD_ID;
    end

    // Divider start requests
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = pfat_pkg::DIV_DVD_W'(size_reg);
        div_req.divisor  = eff_ps;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.action == pfat_pkg::ACT_ALLOC)
                    && (count_reg < pfat_pkg::PROC_CNT_W'(pfat_pkg::MAX_PROCESSES)))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = frames_ok_reg
                                     ? pfat_pkg::DIV_DVD_W'(req.process_size)
                                     : memory_size_reg;
                end
            end
            S_FRAMES:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = pfat_pkg::DIV_DVD_W'(size_reg);
            end
            S_CHECK:
            begin
                div_req.start    = (tab_rd_data.pages != '0)
                                && (pfat_pkg::PSIZE_W'(addr_reg) < tab_rd_data.size);
                div_req.dividend = pfat_pkg::DIV_DVD_W'(addr_reg);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Process table access
    always_comb
    begin
        tab_rd_en   = (state_reg == S_RDTAB);
        tab_rd_addr = pfat_pkg::PROC_IDX_W'(pid_reg - 1'b1);
        tab_wr.we   = (state_reg == S_ALLOC);
        tab_wr.addr = pfat_pkg::PROC_IDX_W'(count_reg);
        tab_wr.entry.size  = size_reg;
        tab_wr.entry.base  = fit_ok ? pfat_pkg::FRAME_W'(nff_reg) : '0;
        tab_wr.entry.pages = fit_ok ? pfat_pkg::FRAME_CNT_W'(pages_reg) : '0;
    end

    pfat_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    pfat_ptab u_ptab
    (
        .clk     (clk),
        .wr      (tab_wr),
        .rd_en   (tab_rd_en),
        .rd_addr (tab_rd_addr),
        .rd_data (tab_rd_data)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            memory_size_reg <= pfat_pkg::MEM_SIZE_RST;
            page_size_reg   <= pfat_pkg::PAGE_SIZE_RST;
            frames_ok_reg   <= 1'b0;
            frames_reg      <= '0;
            count_reg       <= '0;
            nff_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                frames_ok_reg <= 1'b0;
                unique case (cfg.index)
                    pfat_pkg::CFG_MEMORY_SIZE:
                    begin
                        memory_size_reg <= cfg.data[pfat_pkg::MEM_SIZE_W-1:0];
                    end
                    pfat_pkg::CFG_PAGE_SIZE:
                    begin
                        page_size_reg <= cfg.data[pfat_pkg::PAGE_SIZE_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        if (req.action == pfat_pkg::ACT_ALLOC)
                        begin
                            if (count_reg >= pfat_pkg::PROC_CNT_W'(pfat_pkg::MAX_PROCESSES))
                            begin
                                state_reg <= S_EMIT;
                            end
                            else if (frames_ok_reg)
                            begin
                                state_reg <= S_PAGES;
                            end
                            else
                            begin
                                state_reg <= S_FRAMES;
                            end
                        end
                        else if ((req.process_id == '0)
                                 || (req.process_id > pfat_pkg::PID_W'(count_reg)))
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_RDTAB;
                        end
                    end
                end
                S_FRAMES:
                begin
                    if (div_rsp.done)
                    begin
                        frames_reg    <= frames_next;
                        frames_ok_reg <= 1'b1;
                        state_reg     <= S_PAGES;
                    end
                end
                S_PAGES:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_ALLOC;
                    end
                end
                S_ALLOC:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (fit_ok)
                    begin
                        nff_reg <= pfat_pkg::FRAME_CNT_W'(fit_sum);
                    end
                    state_reg <= S_EMIT;
                end
                S_RDTAB:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    state_reg <= div_req.start ? S_XDIV : S_EMIT;
                end
                S_XDIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (pfat_pkg::PAGE_NUM_W'(div_rsp.quot) >=
                            pfat_pkg::PAGE_NUM_W'(ent_reg.pages))
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_PHYS;
                end
                S_PHYS:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            size_reg   <= req.process_size;
            pid_reg    <= req.process_id;
            addr_reg   <= req.logical_address;
            res_reg    <= res_start;
        end

        if ((state_reg == S_PAGES) && div_rsp.done)
        begin
            pages_reg <= pages_next;
        end

        if (state_reg == S_ALLOC)
        begin
            if (fit_ok)
            begin
                res_reg.status        <= pfat_pkg::ST_OK;
                res_reg.frame_number  <= pfat_pkg::FRAME_W'(nff_reg);
                res_reg.pages_granted <= pfat_pkg::GRANT_W'(pages_reg);
            end
            else
            begin
                res_reg.status <= pfat_pkg::ST_NO_FRAMES;
            end
        end

        if (state_reg == S_CHECK)
        begin
            ent_reg <= tab_rd_data;
            if (tab_rd_data.pages == '0)
            begin
                res_reg.status <= pfat_pkg::ST_NO_PAGES;
            end
            else if (pfat_pkg::PSIZE_W'(addr_reg) >= tab_rd_data.size)
            begin
                res_reg.status <= pfat_pkg::ST_BAD_ADDR;
            end
        end

        if ((state_reg == S_XDIV) && div_rsp.done)
        begin
            pg_reg    <= pfat_pkg::PAGE_NUM_W'(div_rsp.quot);
            off_reg   <= pfat_pkg::PAGE_OFF_W'(div_rsp.rem);
            frame_reg <= ent_reg.base + pfat_pkg::FRAME_W'(div_rsp.quot);
            res_reg.status <= pfat_pkg::ST_FAULT;
        end

        if (state_reg == S_MUL)
        begin
            prod_reg <= frame_reg * eff_ps;
        end

        if (state_reg == S_PHYS)
        begin
            res_reg.status           <= pfat_pkg::ST_OK;
            res_reg.page_number      <= pg_reg;
            res_reg.page_offset      <= off_reg;
            res_reg.frame_number     <= frame_reg;
            res_reg.physical_address <= pfat_pkg::PADDR_W'(prod_reg)
                                      + pfat_pkg::PADDR_W'(off_reg);
        end

        if (emit_go)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_reg.status;
    assign rsp.page_number      = out_reg.page_number;
    assign rsp.page_offset      = out_reg.page_offset;
    assign rsp.frame_number     = out_reg.frame_number;
    assign rsp.physical_address = out_reg.physical_address;
    assign rsp.pages_granted    = out_reg.pages_granted;

    // Process count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pfat_pkg::PROC_CNT_W'(pfat_pkg::MAX_PROCESSES))
        else $error("process count beyond table depth");

    // Every allocation that reaches the fit check registers one process.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("allocation did not register a process");

    // Frames handed out stay within the frame limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        nff_reg <= pfat_pkg::FRAME_CNT_W'(pfat_pkg::MAX_FRAMES))
        else $error("next free frame beyond frame limit");

    // A result handed over shows up on the output channel next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("result lost on hand-over");

endmodule

FILE: sim/testbench.sv
// Testbench: checks the paged frame allocator against an in-bench page-table model.
`timescale 1ns / 1ps

module testbench;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off for the pressure test
    localparam int SETTLE_GAP   = 8;       // quiet cycles after the last result
    localparam int DRAIN_GAP    = 60;      // watch window for stray results at the end
    localparam int PHASE_ITEMS  = 205;
    localparam int DUE_IDX_W    = 4;
    localparam int DUE_DEPTH    = 1 << DUE_IDX_W;  // far above the few requests in flight

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pfat_cfg_if cfg_ch();
    pfat_req_if req_ch();
    pfat_rsp_if rsp_ch();

    paged_frame_alloc_translate u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Page-table model: our own copy of the configuration and the process
    // table, advanced once per accepted request.
    // ------------------------------------------------------------------
    logic [pfat_pkg::MEM_SIZE_W-1:0]  cur_mem_kb  = pfat_pkg::MEM_SIZE_RST;
    logic [pfat_pkg::PAGE_SIZE_W-1:0] cur_page_kb = pfat_pkg::PAGE_SIZE_RST;
    int unsigned                      proc_total  = 0;
    int unsigned                      free_frame  = 0;
    logic [pfat_pkg::PSIZE_W-1:0]     proc_kb    [pfat_pkg::MAX_PROCESSES];
    int unsigned                      proc_base  [pfat_pkg::MAX_PROCESSES];  // may hold 1024
    int unsigned                      proc_pages [pfat_pkg::MAX_PROCESSES];

    // Expected responses, oldest first: a ring with free-running counters.
    pfat_pkg::result_t due_ring [DUE_DEPTH];
    int unsigned       due_wr = 0;
    int unsigned       due_rd = 0;

    int  mismatch_count = 0;
    int  results_seen   = 0;
    bit  calm           = 1'b0;     // no idling on either side once set
    bit  hold_go        = 1'b0;
    logic rsp_hold;
    int  stall_left     = 0;
    int  cycle_count    = 0;

    // Allocation or translation of one request against the model table.
    function automatic pfat_pkg::result_t compute_page_result(
        input logic                          act,
        input logic [pfat_pkg::PSIZE_W-1:0]  kb,
        input logic [pfat_pkg::PID_W-1:0]    pid,
        input logic [pfat_pkg::LADDR_W-1:0]  laddr);
        pfat_pkg::result_t r;
        int unsigned       ps, frames, pages, pg, off, frame;
        int unsigned       idx;
        r = '0;
        // a page size of zero behaves as one
        if (cur_page_kb == '0)
            ps = 1;
        else
            ps = 32'(cur_page_kb);
        if (act == pfat_pkg::ACT_ALLOC)
        begin
            if (proc_total >= pfat_pkg::MAX_PROCESSES)
            begin
                r.status = pfat_pkg::ST_FULL;
            end
            else
            begin
                idx = proc_total;
                proc_total++;
                proc_kb[idx] = kb;
                frames = 32'(cur_mem_kb) / ps;
                if (frames > pfat_pkg::MAX_FRAMES)
                    frames = pfat_pkg::MAX_FRAMES;
                pages = (32'(kb) + ps - 1) / ps;
                if (free_frame + pages > frames)
                begin
                    // registered, but with no pages
                    proc_base[idx]  = 0;
                    proc_pages[idx] = 0;
                    r.status = pfat_pkg::ST_NO_FRAMES;
                end
                else
                begin
                    proc_base[idx]  = free_frame;
                    proc_pages[idx] = pages;
                    free_frame     += pages;
                    r.status        = pfat_pkg::ST_OK;
                    r.frame_number  = pfat_pkg::FRAME_W'(proc_base[idx]);
                    r.pages_granted = pfat_pkg::GRANT_W'(pages);
                end
            end
        end
        else
        begin
            if (pid == '0 || 32'(pid) > proc_total)
            begin
                r.status = pfat_pkg::ST_BAD_ID;
            end
            else
            begin
                idx = 32'(pid) - 1;
                if (proc_pages[idx] == 0)
                begin
                    r.status = pfat_pkg::ST_NO_PAGES;
                end
                else if (laddr >= proc_kb[idx])
                begin
                    r.status = pfat_pkg::ST_BAD_ADDR;
                end
                else
                begin
                    pg  = 32'(laddr) / ps;
                    off = 32'(laddr) % ps;
                    // page size changed since allocation: index past the run
                    if (pg >= proc_pages[idx])
                    begin
                        r.status = pfat_pkg::ST_FAULT;
                    end
                    else
                    begin
                        frame              = proc_base[idx] + pg;
                        r.status           = pfat_pkg::ST_OK;
                        r.page_number      = pfat_pkg::PAGE_NUM_W'(pg);
                        r.page_offset      = pfat_pkg::PAGE_OFF_W'(off);
                        r.frame_number     = pfat_pkg::FRAME_W'(frame);
                        r.physical_address = pfat_pkg::PADDR_W'(frame * ps + off);
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch on response %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Response side. The checker samples at the edge, ahead of any update
    // from the block; ready is driven with a nonblocking assignment.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pfat_pkg::result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (due_rd == due_wr)
            begin
                report_mismatch("response with no request pending", rsp_ch.status, -1);
            end
            else
            begin
                want = due_ring[due_rd[DUE_IDX_W-1:0]];
                due_rd++;
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.page_number !== want.page_number)
                    report_mismatch("page_number", rsp_ch.page_number, want.page_number);
                if (rsp_ch.page_offset !== want.page_offset)
                    report_mismatch("page_offset", rsp_ch.page_offset, want.page_offset);
                if (rsp_ch.frame_number !== want.frame_number)
                    report_mismatch("frame_number", rsp_ch.frame_number, want.frame_number);
                if (rsp_ch.physical_address !== want.physical_address)
                    report_mismatch("physical_address", rsp_ch.physical_address,
                                    want.physical_address);
                if (rsp_ch.pages_granted !== want.pages_granted)
                    report_mismatch("pages_granted", rsp_ch.pages_granted, want.pages_granted);
            end
        end
    end

    // Receiver stalls: bursts of random length, plus the long hold-off.
    always @(posedge clk)
    begin
        if (rsp_hold)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Long hold-off, counted here so the sender keeps offering meanwhile.
    initial
    begin
        rsp_hold <= 1'b0;
        wait (hold_go);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side. Every task below is entered just after a rising edge.
    // valid stays high from one request to the next unless a gap is drawn.
    // ------------------------------------------------------------------
    task automatic send_request(input logic act,
                                input logic [pfat_pkg::PSIZE_W-1:0] kb,
                                input logic [pfat_pkg::PID_W-1:0] pid,
                                input logic [pfat_pkg::LADDR_W-1:0] laddr);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.action          <= act;
        req_ch.process_size    <= kb;
        req_ch.process_id      <= pid;
        req_ch.logical_address <= laddr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        due_ring[due_wr[DUE_IDX_W-1:0]] = compute_page_result(act, kb, pid, laddr);
        due_wr++;
    endtask

    // Drop valid and wait until the block has answered everything.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (due_wr != due_rd)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // Writes both registers; only called while the block is idle.
    task automatic write_config(input logic [pfat_pkg::MEM_SIZE_W-1:0] mem_kb,
                                input logic [pfat_pkg::PAGE_SIZE_W-1:0] page_kb);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= pfat_pkg::CFG_MEMORY_SIZE;
        cfg_ch.data  <= pfat_pkg::CFG_DATA_W'(mem_kb);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cur_mem_kb = mem_kb;
        cfg_ch.index <= pfat_pkg::CFG_PAGE_SIZE;
        cfg_ch.data  <= pfat_pkg::CFG_DATA_W'(page_kb);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cur_page_kb = page_kb;
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed translations of registered processes, some noise,
    // and a trickle of allocations (which turn into table-full once 16 exist).
    task automatic send_random_request();
        int unsigned                    pick, ps, sz, pid, mode;
        logic [pfat_pkg::LADDR_W-1:0]   addr;
        pick = $urandom_range(0, 99);
        if (cur_page_kb == '0)
            ps = 1;
        else
            ps = 32'(cur_page_kb);
        if (pick < 3)
        begin
            case ($urandom_range(0, 2))
                0:       sz = $urandom_range(0, 65535);
                1:       sz = ps * $urandom_range(0, 6) + $urandom_range(0, 2);
                default: sz = $urandom_range(0, 3);
            endcase
            if (sz > 65535)
                sz = 65535;
            send_request(pfat_pkg::ACT_ALLOC, pfat_pkg::PSIZE_W'(sz),
                         pfat_pkg::PID_W'($urandom), pfat_pkg::LADDR_W'($urandom));
        end
        else if (pick < 15 || proc_total == 0)
        begin
            send_request(pfat_pkg::ACT_XLATE, pfat_pkg::PSIZE_W'($urandom),
                         pfat_pkg::PID_W'($urandom), pfat_pkg::LADDR_W'($urandom));
        end
        else
        begin
            pid  = $urandom_range(1, proc_total);
            sz   = 32'(proc_kb[pid - 1]);
            mode = $urandom_range(0, 3);
            if (mode <= 1)
                addr = (sz == 0) ? '0 : pfat_pkg::LADDR_W'($urandom_range(0, sz - 1));
            else if (mode == 2)
                addr = pfat_pkg::LADDR_W'(sz - $urandom_range(0, 1));  // last byte / one past
            else
                addr = pfat_pkg::LADDR_W'($urandom);
            send_request(pfat_pkg::ACT_XLATE, pfat_pkg::PSIZE_W'($urandom),
                         pfat_pkg::PID_W'(pid), addr);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Id zero, an id with nothing registered, and the largest id.
    task automatic test_bad_ids();
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(0), '0);
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(1), '0);
        send_request(pfat_pkg::ACT_XLATE, '1, '1, '1);
    endtask

    // Reset config gives 8 frames: zero-size, 3 pages, refused, then 5 pages to fill up.
    task automatic test_allocation();
        send_request(pfat_pkg::ACT_ALLOC, pfat_pkg::PSIZE_W'(0), '0, '0);
        send_request(pfat_pkg::ACT_ALLOC, pfat_pkg::PSIZE_W'(300), '0, '0);
        send_request(pfat_pkg::ACT_ALLOC, pfat_pkg::PSIZE_W'(1024), '0, '0);
        send_request(pfat_pkg::ACT_ALLOC, pfat_pkg::PSIZE_W'(640), '0, '0);
    endtask

    // No pages, in-bound edges, out-of-bound addresses, and one past the table.
    task automatic test_translation();
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(1), pfat_pkg::LADDR_W'(0));
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(2), pfat_pkg::LADDR_W'(0));
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(2), pfat_pkg::LADDR_W'(299));
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(2), pfat_pkg::LADDR_W'(300));
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(2), '1);
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(3), pfat_pkg::LADDR_W'(0));
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(4), pfat_pkg::LADDR_W'(639));
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(5), pfat_pkg::LADDR_W'(0));
    endtask

    // Page size written as zero (acts as one) with memory at its top: page
    // indexes now run past the original runs, which must fault.
    task automatic test_zero_page_and_fault();
        wait_idle();
        write_config('1, '0);
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(2), pfat_pkg::LADDR_W'(2));
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(2), pfat_pkg::LADDR_W'(3));
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(2), pfat_pkg::LADDR_W'(299));
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(4), pfat_pkg::LADDR_W'(4));
        send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(4), pfat_pkg::LADDR_W'(5));
        send_request(pfat_pkg::ACT_ALLOC, pfat_pkg::PSIZE_W'(16), '0, '0);
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_stall_pressure();
        int n;
        hold_go = 1'b1;
        for (n = 0; n < 24; n++)
            send_random_request();
    endtask

    // Phases over several settings, extremes among them.
    task automatic test_random_phases();
        int phase, n;
        for (phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            case (phase)
                0:       write_config('1, pfat_pkg::PAGE_SIZE_W'(1));
                1:       write_config(pfat_pkg::MEM_SIZE_W'($urandom_range(0, 1048575)),
                                      pfat_pkg::PAGE_SIZE_W'($urandom_range(1, 2048)));
                2:       write_config(pfat_pkg::MEM_SIZE_W'(1), '1);
                3:       write_config(pfat_pkg::MEM_SIZE_W'($urandom),
                                      pfat_pkg::PAGE_SIZE_W'($urandom));
                4:       write_config(pfat_pkg::MEM_SIZE_W'($urandom), '0);
                default: write_config('1, '1);
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_request();
        end
    endtask

    // Last part, no idling: fill the table, overflow it, then touch every process.
    task automatic test_table_full();
        int n;
        calm = 1'b1;
        wait_idle();
        write_config('1, pfat_pkg::PAGE_SIZE_W'(64));
        while (proc_total < pfat_pkg::MAX_PROCESSES)
            send_request(pfat_pkg::ACT_ALLOC, pfat_pkg::PSIZE_W'($urandom_range(0, 200)),
                         '0, '0);
        for (n = 0; n < 3; n++)
            send_request(pfat_pkg::ACT_ALLOC, pfat_pkg::PSIZE_W'($urandom), '0, '0);
        for (n = 1; n <= pfat_pkg::MAX_PROCESSES; n++)
            send_request(pfat_pkg::ACT_XLATE, '0, pfat_pkg::PID_W'(n),
                         pfat_pkg::LADDR_W'($urandom_range(0, proc_kb[n - 1])));
    endtask

    initial
    begin
        req_ch.valid           <= 1'b0;
        req_ch.action          <= pfat_pkg::ACT_ALLOC;
        req_ch.process_size    <= '0;
        req_ch.process_id      <= '0;
        req_ch.logical_address <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= pfat_pkg::CFG_MEMORY_SIZE;
        cfg_ch.data            <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bad_ids();
        test_allocation();
        test_translation();
        test_zero_page_and_fault();
        test_stall_pressure();
        test_random_phases();
        test_table_full();

        wait_idle();
        repeat (DRAIN_GAP) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/pfat_pkg.sv
sv/pfat_ifs.sv
sv/pfat_div.sv
sv/pfat_ptab.sv
sv/paged_frame_alloc_translate.sv
sim/testbench.sv
